/* hdl/ftog_pkg.sv */
// Shared types and constants for the fan tachometer output generator.
package ftog_pkg;

    localparam int DEF_NUM_FANS = 6;

    localparam int MODE_W  = 4;
    localparam int MASK_W  = 6;
    localparam int PWM_W   = 18;
    localparam int RPS_W   = 8;
    localparam int RPM_W   = 16;
    localparam int IVL_W   = 16;
    localparam int IDX_W   = 3;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam int DIV_BITS = IVL_W;
    localparam int DIV_CW   = $clog2(DIV_BITS);

    localparam logic [MODE_W-1:0] OUT_FIXED50 = 4'd6;
    localparam logic [MODE_W-1:0] OUT_MINFAN  = 4'd7;
    localparam logic [MODE_W-1:0] OUT_MAXFAN  = 4'd8;

    localparam logic [RPS_W-1:0] FIXED_RPS = 8'd50;
    localparam logic [RPM_W-1:0] FIXED_RPM = 16'(50 * 60);

    localparam logic [MODE_W-1:0] RST_OUT_MODE = OUT_FIXED50;
    localparam logic [MASK_W-1:0] RST_MASK     = '0;
    localparam logic [PWM_W-1:0]  RST_PWM      = 18'd25000;

    typedef enum logic [1:0] {
        REG_OUT_MODE   = 2'd0,
        REG_STALL_MASK = 2'd1,
        REG_PWM_FREQ   = 2'd2,
        REG_NONE       = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ITEM_TICK      = 2'd0,
        ITEM_REPORT    = 2'd1,
        ITEM_RECOMPUTE = 2'd2,
        ITEM_RESTART   = 2'd3
    } t_item_mode;

    typedef struct packed {
        t_item_mode         mode;
        logic [IVL_W-1:0]   timer_count;
        logic [IDX_W-1:0]   fan_index;
        logic               fan_has_tacho;
        logic               fan_stalled;
        logic [15:0]        fan_rps_fixed;
        logic [RPM_W-1:0]   fan_rpm;
    } t_in_word;

    typedef struct packed {
        logic               tacho_drive_low;
        logic [RPS_W-1:0]   out_rps;
        logic [RPM_W-1:0]   out_rpm;
        logic [IVL_W-1:0]   toggle_interval;
    } t_out_word;

endpackage

/* hdl/fan_tacho_output_generator.sv */
// Fan tachometer output generator: fan table, speed selection, bit-serial divider, toggle timer.
// Timer ticks, fan reports and deadline restarts are taken in S_IDLE, and their result word is
// posted from S_DONE. A recompute passes through S_IDLE to take the word, S_CLONE to read the
// cloned fan, S_SCAN for the stall and min/max scan over the fans, S_DIV_INIT to set up the
// divider, S_DIV for the restoring divider that retires one quotient bit per cycle, and S_DONE
// to post the result word. A zero speed skips the divider, and a stalled fan in the mask ends
// the scan early. One word is in work at a time; the next is taken while the previous result
// still sits in the output register.
module fan_tacho_output_generator
    import ftog_pkg::*;
#(
    parameter int NUM_FANS = DEF_NUM_FANS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  t_in_word          i_in_word,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output t_out_word         o_out_word,
    input  logic              i_out_stall,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int FW = (NUM_FANS > 1) ? $clog2(NUM_FANS) : 1;
    localparam logic [MODE_W-1:0] NF_MODE = MODE_W'(NUM_FANS);
    localparam logic [FW-1:0] LAST_FAN = FW'(NUM_FANS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLONE,
        S_SCAN,
        S_DIV_INIT,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    logic [MODE_W-1:0] r_out_mode, n_out_mode;
    logic [MASK_W-1:0] r_mask, n_mask;
    logic [PWM_W-1:0]  r_pwm, n_pwm;

    logic [RPS_W-1:0] r_spd [NUM_FANS];
    logic [RPS_W-1:0] n_spd [NUM_FANS];
    logic [RPM_W-1:0] r_rpm [NUM_FANS];
    logic [RPM_W-1:0] n_rpm [NUM_FANS];
    logic [NUM_FANS-1:0] r_tacho, n_tacho;
    logic [NUM_FANS-1:0] r_stall, n_stall;

    logic [RPS_W-1:0] r_cur_rps, n_cur_rps;
    logic [RPM_W-1:0] r_cur_rpm, n_cur_rpm;
    logic [IVL_W-1:0] r_interval, n_interval;
    logic [IVL_W-1:0] r_deadline, n_deadline;
    logic             r_drive, n_drive;

    logic [FW-1:0]     r_k, n_k;
    logic              r_first, n_first;
    logic [IVL_W-1:0]  r_quo, n_quo;
    logic [RPS_W-1:0]  r_rem, n_rem;
    logic [DIV_CW-1:0] r_cnt, n_cnt;

    logic      r_out_valid, n_out_valid;
    t_out_word r_out, n_out;

    logic             in_acc;
    logic             cfg_wr;
    t_reg_idx         cfg_idx;
    logic [FW-1:0]    rd_idx;
    logic [RPS_W-1:0] rd_spd;
    logic [RPM_W-1:0] rd_rpm;
    logic             clone_ok;
    logic [RPS_W:0]   rem_sh;
    logic [RPS_W:0]   rem_dif;
    logic             div_ge;
    logic [FW-1:0]    wr_idx;
    logic             wr_ok;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign cfg_idx     = t_reg_idx'(paddr[3:2]);

    always_comb begin
        case (cfg_idx)
            REG_OUT_MODE:   prdata = APB_DW'(r_out_mode);
            REG_STALL_MASK: prdata = APB_DW'(r_mask);
            REG_PWM_FREQ:   prdata = APB_DW'(r_pwm);
            default:        prdata = '0;
        endcase
    end

    // one table read port, shared by the clone read and the scan
    assign clone_ok = (r_out_mode < OUT_FIXED50) && (r_out_mode < NF_MODE);
    assign rd_idx   = (r_state == S_CLONE) ? r_out_mode[FW-1:0] : r_k;
    assign rd_spd   = r_spd[rd_idx];
    assign rd_rpm   = r_rpm[rd_idx];

    assign rem_sh  = {r_rem, r_quo[IVL_W-1]};
    assign div_ge  = rem_sh >= {1'b0, r_cur_rps};
    assign rem_dif = rem_sh - {1'b0, r_cur_rps};

    assign wr_idx = i_in_word.fan_index[FW-1:0];
    assign wr_ok  = ({1'b0, i_in_word.fan_index} < NF_MODE);

    always_comb begin
        n_state     = r_state;
        n_out_mode  = r_out_mode;
        n_mask      = r_mask;
        n_pwm       = r_pwm;
        n_spd       = r_spd;
        n_rpm       = r_rpm;
        n_tacho     = r_tacho;
        n_stall     = r_stall;
        n_cur_rps   = r_cur_rps;
        n_cur_rpm   = r_cur_rpm;
        n_interval  = r_interval;
        n_deadline  = r_deadline;
        n_drive     = r_drive;
        n_k         = r_k;
        n_first     = r_first;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (cfg_wr) begin
            case (cfg_idx)
                REG_OUT_MODE:   n_out_mode = pwdata[MODE_W-1:0];
                REG_STALL_MASK: n_mask     = pwdata[MASK_W-1:0];
                REG_PWM_FREQ:   n_pwm      = pwdata[PWM_W-1:0];
                default:        ;
            endcase
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_DONE;
                    case (i_in_word.mode)
                        ITEM_TICK: begin
                            if (i_in_word.timer_count >= r_deadline) begin
                                n_deadline = r_deadline + r_interval;
                                n_drive    = ~r_drive;
                            end
                        end
                        ITEM_REPORT: begin
                            if (wr_ok) begin
                                n_tacho[wr_idx] = i_in_word.fan_has_tacho;
                                n_stall[wr_idx] = i_in_word.fan_stalled;
                                n_spd[wr_idx]   = i_in_word.fan_rps_fixed[15:8];
                                n_rpm[wr_idx]   = i_in_word.fan_rpm;
                            end
                        end
                        ITEM_RECOMPUTE: n_state = S_CLONE;
                        ITEM_RESTART:   n_deadline = r_interval;
                        default:        ;
                    endcase
                end
            end
            S_CLONE: begin
                if (clone_ok) begin
                    n_cur_rps = rd_spd;
                    n_cur_rpm = rd_rpm;
                end else if (r_out_mode == OUT_FIXED50) begin
                    n_cur_rps = FIXED_RPS;
                    n_cur_rpm = FIXED_RPM;
                end else begin
                    n_cur_rps = '0;
                    n_cur_rpm = '0;
                end
                n_first = 1'b1;
                n_k     = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                n_k = r_k + 1'b1;
                if (r_k == LAST_FAN) begin
                    n_state = S_DIV_INIT;
                end
                if (r_tacho[r_k]) begin
                    if (r_mask[r_k] && r_stall[r_k]) begin
                        n_cur_rps = '0;
                        n_cur_rpm = '0;
                        n_state   = S_DIV_INIT;
                    end else if (r_out_mode == OUT_MINFAN) begin
                        if (r_first || (r_cur_rps > rd_spd)) begin
                            n_cur_rps = rd_spd;
                            n_cur_rpm = rd_rpm;
                            n_first   = 1'b0;
                        end
                    end else if (r_out_mode == OUT_MAXFAN) begin
                        if (r_first || (r_cur_rps < rd_spd)) begin
                            n_cur_rps = rd_spd;
                            n_cur_rpm = rd_rpm;
                            n_first   = 1'b0;
                        end
                    end
                end
            end
            S_DIV_INIT: begin
                if (r_cur_rps == '0) begin
                    n_interval = '1;
                    n_state    = S_DONE;
                end else begin
                    n_quo   = r_pwm[PWM_W-1:2];
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // dividend fits 16 bits, divisor is nonzero: quotient never saturates
                n_rem = div_ge ? rem_dif[RPS_W-1:0] : rem_sh[RPS_W-1:0];
                n_quo = {r_quo[IVL_W-2:0], div_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(DIV_BITS - 1)) begin
                    n_interval = {r_quo[IVL_W-2:0], div_ge};
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid           = 1'b1;
                    n_out.tacho_drive_low = r_drive;
                    n_out.out_rps         = r_cur_rps;
                    n_out.out_rpm         = r_cur_rpm;
                    n_out.toggle_interval = r_interval;
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_mode  <= RST_OUT_MODE;
            r_mask      <= RST_MASK;
            r_pwm       <= RST_PWM;
            for (int i = 0; i < NUM_FANS; i++) begin
                r_spd[i] <= '0;
                r_rpm[i] <= '0;
            end
            r_tacho     <= '0;
            r_stall     <= '0;
            r_cur_rps   <= '0;
            r_cur_rpm   <= '0;
            r_interval  <= '0;
            r_deadline  <= '0;
            r_drive     <= 1'b0;
            r_k         <= '0;
            r_first     <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_mode  <= n_out_mode;
            r_mask      <= n_mask;
            r_pwm       <= n_pwm;
            r_spd       <= n_spd;
            r_rpm       <= n_rpm;
            r_tacho     <= n_tacho;
            r_stall     <= n_stall;
            r_cur_rps   <= n_cur_rps;
            r_cur_rpm   <= n_cur_rpm;
            r_interval  <= n_interval;
            r_deadline  <= n_deadline;
            r_drive     <= n_drive;
            r_k         <= n_k;
            r_first     <= n_first;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_out <= n_out;
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("accepted word left the block idle");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ({1'b0, r_k} < NF_MODE))
        else $error("fan scan index out of range");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ((r_cur_rps != '0) && (r_rem < r_cur_rps)))
        else $error("divider remainder not below divisor");

    a_zero_speed_ivl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV_INIT) && (r_cur_rps == '0)) |=> (r_interval == '1))
        else $error("zero speed did not give full interval");

endmodule
